@@ rtl/smci_pkg.sv @@
// ----------------------------------------------------------------------------
// smci_pkg
// Shared types, character codes and decode function for the character
// stack interpreter.
// ----------------------------------------------------------------------------
package smci_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned AddrW = 16;
  localparam int unsigned CharW = 8;
  localparam int unsigned KindW = 3;

  // Event kinds reported with each result item.
  localparam logic [KindW-1:0] KIND_NONE    = 3'd0;
  localparam logic [KindW-1:0] KIND_PRINT   = 3'd1;
  localparam logic [KindW-1:0] KIND_PUTC    = 3'd2;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 3'd3;
  localparam logic [KindW-1:0] KIND_DIVZERO = 3'd4;

  // Program character codes.
  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] CH_NINE   = 8'h39;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
  localparam logic [CharW-1:0] CH_ADD    = 8'h2B;
  localparam logic [CharW-1:0] CH_SUB    = 8'h2D;
  localparam logic [CharW-1:0] CH_MUL    = 8'h2A;
  localparam logic [CharW-1:0] CH_DIV    = 8'h2F;
  localparam logic [CharW-1:0] CH_DUP    = 8'h64;
  localparam logic [CharW-1:0] CH_SWAP   = 8'h5E;
  localparam logic [CharW-1:0] CH_LOAD   = 8'h6C;
  localparam logic [CharW-1:0] CH_STORE  = 8'h73;
  localparam logic [CharW-1:0] CH_ADDR   = 8'h40;
  localparam logic [CharW-1:0] CH_JUMP   = 8'h21;
  localparam logic [CharW-1:0] CH_JUMPIF = 8'h3F;
  localparam logic [CharW-1:0] CH_PRINT  = 8'h2E;
  localparam logic [CharW-1:0] CH_SERIAL = 8'h2C;
  localparam logic [CharW-1:0] CH_PUTC   = 8'h24;

  typedef enum logic [4:0] {
    OP_DIGIT, OP_SPACE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DUP, OP_SWAP,
    OP_LOAD, OP_STORE, OP_ADDR, OP_JUMP, OP_JUMPIF, OP_PRINT, OP_SERIAL,
    OP_PUTC, OP_UNKNOWN
  } op_e;

  // Source of the value written by a push.
  typedef enum logic [3:0] {
    PUSH_SUM, PUSH_DIFF, PUSH_PROD, PUSH_QUOT, PUSH_ZERO, PUSH_LOAD,
    PUSH_NEXT, PUSH_SERIAL, PUSH_T1, PUSH_T2
  } push_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      take;
    logic      digit;
    logic      flush;
    logic      pop;
    logic      cap1;
    logic      cap2;
    logic      push;
    push_src_e push_src;
    logic      mul_step;
    logic      div_start;
    logic      div_mod;
    logic      load_rd;
    logic      store;
    logic      apply;
    logic      out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    op_e  op;
    logic last;
    logic rd_pos;
    logic t1_zero;
    logic mul_last;
    logic div_done;
  } dp_stat_t;

  function automatic op_e decode_op(logic [CharW-1:0] ch);
    op_e op;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      op = OP_DIGIT;
    end else begin
      unique case (ch)
        CH_SPACE:  op = OP_SPACE;
        CH_ADD:    op = OP_ADD;
        CH_SUB:    op = OP_SUB;
        CH_MUL:    op = OP_MUL;
        CH_DIV:    op = OP_DIV;
        CH_DUP:    op = OP_DUP;
        CH_SWAP:   op = OP_SWAP;
        CH_LOAD:   op = OP_LOAD;
        CH_STORE:  op = OP_STORE;
        CH_ADDR:   op = OP_ADDR;
        CH_JUMP:   op = OP_JUMP;
        CH_JUMPIF: op = OP_JUMPIF;
        CH_PRINT:  op = OP_PRINT;
        CH_SERIAL: op = OP_SERIAL;
        CH_PUTC:   op = OP_PUTC;
        default:   op = OP_UNKNOWN;
      endcase
    end
    return op;
  endfunction

endpackage

@@ rtl/stack_machine_char_interpreter.sv @@
// ----------------------------------------------------------------------------
// stack_machine_char_interpreter
// Executes a one-character-per-op stack language on a 64-bit data stack,
// one program character per input item, one result item per input item.
//
//   Channel  Handshake              Payload
//   in       in_valid_i/in_ready_o   program_char, char_address, serial_char,
//                                    final_char
//   out      out_valid_o/out_ready_i event_kind, event_value, next_address,
//                                    stack_fault
//
// A multiply makes three passes through one 32x32 multiplier, a divide waits on
// the one-bit-per-cycle divider, and a divide by zero skips it. Load and store
// wait on the slot reduction that takes four index bits per cycle. After reset
// a clearing pass zeroes the stack memory while no item is accepted. A new item
// is accepted while a result still waits in the output register; the block
// stalls only when finishing.
// ----------------------------------------------------------------------------
module stack_machine_char_interpreter #(
  parameter int unsigned STACK_DEPTH  = 256,
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [smci_pkg::CharW-1:0]        program_char_i,
  input  logic [smci_pkg::AddrW-1:0]        char_address_i,
  input  logic [smci_pkg::CharW-1:0]        serial_char_i,
  input  logic                              final_char_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [smci_pkg::KindW-1:0]        event_kind_o,
  output logic signed [smci_pkg::DataW-1:0] event_value_o,
  output logic [smci_pkg::AddrW-1:0]        next_address_o,
  output logic                              stack_fault_o
);

  smci_pkg::dp_cmd_t          cmd;
  smci_pkg::dp_stat_t         stat;
  logic [smci_pkg::DataW-1:0] value;

  smci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  smci_dp #(
    .STACK_DEPTH  (STACK_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .program_char_i (program_char_i),
    .char_address_i (char_address_i),
    .serial_char_i  (serial_char_i),
    .final_char_i   (final_char_i),
    .event_kind_o   (event_kind_o),
    .event_value_o  (value),
    .next_address_o (next_address_o),
    .stack_fault_o  (stack_fault_o)
  );

  assign event_value_o = $signed(value);

endmodule

@@ rtl/smci_div.sv @@
// ----------------------------------------------------------------------------
// smci_div
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smci_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [smci_pkg::DataW-1:0] dividend_i,
  input  logic [smci_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [smci_pkg::DataW-1:0] quot_o
);

  localparam int unsigned W = smci_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dsr_q, dsr_d;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // One shift-subtract step per cycle.
  always_comb begin
    shifted = {rem_q[W-1:0], quo_q[W-1]};
    trial   = shifted - {1'b0, dsr_q};
    run_d   = run_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      run_d  = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (run_q) begin
      if (!trial[W]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/smci_dp.sv @@
// ----------------------------------------------------------------------------
// smci_dp
// Datapath: stack memory, stack pointer, number builder, operand registers,
// shared multiplier, divider, slot reduction and the output register.
// ----------------------------------------------------------------------------
module smci_dp #(
  parameter int unsigned STACK_DEPTH  = 256,
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smci_pkg::dp_cmd_t          cmd_i,
  output smci_pkg::dp_stat_t         stat_o,
  input  logic [smci_pkg::CharW-1:0] program_char_i,
  input  logic [smci_pkg::AddrW-1:0] char_address_i,
  input  logic [smci_pkg::CharW-1:0] serial_char_i,
  input  logic                       final_char_i,
  output logic [smci_pkg::KindW-1:0] event_kind_o,
  output logic [smci_pkg::DataW-1:0] event_value_o,
  output logic [smci_pkg::AddrW-1:0] next_address_o,
  output logic                       stack_fault_o
);

  localparam int unsigned W     = smci_pkg::DataW;
  localparam int unsigned AW    = smci_pkg::AddrW;
  localparam int unsigned CW    = smci_pkg::CharW;
  localparam int unsigned KW    = smci_pkg::KindW;
  localparam int unsigned IdxW  = $clog2(STACK_DEPTH);
  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ModW  = SpW + 4;
  localparam int unsigned MaskBits = (ADDRESS_BITS < AW) ? ADDRESS_BITS : AW;
  localparam logic [AW-1:0] AddrMask = AW'((64'd1 << MaskBits) - 64'd1);
  localparam logic [ModW-1:0] ModDepth = ModW'(STACK_DEPTH);

  // Latched item fields.
  logic [CW-1:0] ch_q;
  logic [CW-1:0] ser_q;
  logic          last_q;
  smci_pkg::op_e op_q;

  // Machine state.
  logic [SpW-1:0] sp_q, sp_d;
  logic [W-1:0]   pend_q, pend_d;
  logic           act_q, act_d;
  logic [W-1:0]   t1_q, t2_q;
  logic [W-1:0]   prod_q;
  logic [1:0]     mcnt_q;
  logic           neg_q;
  logic           fault_q, fault_d;
  logic [KW-1:0]  kind_q;
  logic [W-1:0]   val_q;
  logic [AW-1:0]  next_q;
  logic           next_c_q;

  // Output register.
  logic [KW-1:0]  out_kind_q;
  logic [W-1:0]   out_val_q;
  logic [AW-1:0]  out_next_q;
  logic           out_fault_q;

  // Stack memory and clearing pass.
  logic [W-1:0]    mem [STACK_DEPTH];
  logic [W-1:0]    rd_q;
  logic            rz_q;
  logic [IdxW-1:0] clr_cnt_q;
  logic            clr_done_q;

  // Slot reduction: index modulo depth, four index bits per cycle.
  logic [W-1:0]    msrc_q;
  logic [SpW-1:0]  mrem_q;
  logic [3:0]      mcyc_q;
  logic            mrun_q;
  logic            mdone_q;
  logic [ModW-1:0] mod_t;
  logic            mod_start;

  logic            empty, full, push_en;
  logic [W-1:0]    push_val, rd_val, quot_s;
  logic            we, re;
  logic [IdxW-1:0] waddr, raddr, slot, sp_idx, top_idx;
  logic [W-1:0]    wdata;
  logic [31:0]     mul_a, mul_b;
  logic [W-1:0]    mul_p;
  logic [W-1:0]    div_dvd, div_dvs, div_quot;
  logic            div_done, div_start;

  assign empty   = (sp_q == '0);
  assign full    = (sp_q == SpW'(STACK_DEPTH));
  assign sp_idx  = sp_q[IdxW-1:0];
  assign top_idx = IdxW'(sp_q - 1'b1);
  assign rd_val  = rz_q ? '0 : rd_q;
  assign slot    = mrem_q[IdxW-1:0];
  assign quot_s  = neg_q ? (W'(0) - div_quot) : div_quot;

  // Push value selection.
  always_comb begin
    push_val = '0;
    if (cmd_i.flush) begin
      push_val = pend_q;
    end else begin
      case (cmd_i.push_src)
        smci_pkg::PUSH_SUM:    push_val = t2_q + t1_q;
        smci_pkg::PUSH_DIFF:   push_val = t2_q - t1_q;
        smci_pkg::PUSH_PROD:   push_val = prod_q;
        smci_pkg::PUSH_QUOT:   push_val = quot_s;
        smci_pkg::PUSH_ZERO:   push_val = '0;
        smci_pkg::PUSH_LOAD:   push_val = rd_val;
        smci_pkg::PUSH_NEXT:   push_val = W'({next_c_q, next_q});
        smci_pkg::PUSH_SERIAL: push_val = W'(ser_q);
        smci_pkg::PUSH_T1:     push_val = t1_q;
        smci_pkg::PUSH_T2:     push_val = t2_q;
        default:               push_val = '0;
      endcase
    end
  end

  assign push_en = cmd_i.push | (cmd_i.flush & act_q);

  // Stack pointer, number builder and fault flag.
  always_comb begin
    sp_d    = sp_q;
    pend_d  = pend_q;
    act_d   = act_q;
    fault_d = fault_q;
    if (cmd_i.take) begin
      fault_d = 1'b0;
    end
    if (cmd_i.digit) begin
      pend_d = (pend_q << 3) + (pend_q << 1) + W'(ch_q[3:0]);
      act_d  = 1'b1;
    end
    if (cmd_i.flush && act_q) begin
      pend_d = '0;
      act_d  = 1'b0;
    end
    if (push_en) begin
      if (full) begin
        fault_d = 1'b1;
      end else begin
        sp_d = sp_q + 1'b1;
      end
    end
    if (cmd_i.pop) begin
      if (empty) begin
        fault_d = 1'b1;
      end else begin
        sp_d = sp_q - 1'b1;
      end
    end
  end

  // Memory port selection; the clearing pass owns the write port after reset.
  always_comb begin
    we    = 1'b0;
    waddr = sp_idx;
    wdata = push_val;
    if (!clr_done_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.store) begin
      we    = 1'b1;
      waddr = slot;
      wdata = t2_q;
    end else if (push_en && !full) begin
      we = 1'b1;
    end
    re    = (cmd_i.pop && !empty) || cmd_i.load_rd;
    raddr = cmd_i.load_rd ? slot : top_idx;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Shared 32x32 multiplier, three partial products for the low 64 bits.
  assign mul_a = (mcnt_q == 2'd2) ? t2_q[63:32] : t2_q[31:0];
  assign mul_b = (mcnt_q == 2'd1) ? t1_q[63:32] : t1_q[31:0];
  assign mul_p = W'(mul_a * mul_b);

  // Divider operands are the signed magnitudes.
  assign div_dvd   = t2_q[W-1] ? (W'(0) - t2_q) : t2_q;
  assign div_dvs   = t1_q[W-1] ? (W'(0) - t1_q) : t1_q;
  assign div_start = cmd_i.div_start & ~cmd_i.div_mod;
  assign mod_start = cmd_i.div_start & cmd_i.div_mod;

  smci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Shift four index bits into the remainder and reduce it below the depth.
  always_comb begin
    mod_t = {mrem_q, msrc_q[W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (mod_t >= (ModDepth << k)) begin
        mod_t = mod_t - (ModDepth << k);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      pend_q      <= '0;
      act_q       <= 1'b0;
      fault_q     <= 1'b0;
      rz_q        <= 1'b0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
      op_q        <= smci_pkg::OP_SPACE;
      mcnt_q      <= '0;
      mrun_q      <= 1'b0;
      mdone_q     <= 1'b0;
      mcyc_q      <= '0;
    end else begin
      sp_q    <= sp_d;
      pend_q  <= pend_d;
      act_q   <= act_d;
      fault_q <= fault_d;
      if (!clr_done_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == IdxW'(STACK_DEPTH - 1)) begin
          clr_done_q <= 1'b1;
        end
      end
      if (cmd_i.pop) begin
        rz_q <= empty;
      end else if (cmd_i.load_rd) begin
        rz_q <= 1'b0;
      end
      if (cmd_i.take) begin
        op_q   <= smci_pkg::decode_op(program_char_i);
        mcnt_q <= '0;
      end else if (cmd_i.mul_step) begin
        mcnt_q <= mcnt_q + 1'b1;
      end
      if (mod_start) begin
        mrun_q  <= 1'b1;
        mdone_q <= 1'b0;
        mcyc_q  <= '0;
      end else if (mrun_q) begin
        mcyc_q <= mcyc_q + 1'b1;
        if (mcyc_q == 4'd15) begin
          mrun_q  <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ch_q     <= program_char_i;
      ser_q    <= serial_char_i;
      last_q   <= final_char_i;
      kind_q   <= smci_pkg::KIND_NONE;
      val_q    <= '0;
      next_q   <= AW'(char_address_i + 1'b1) & AddrMask;
      next_c_q <= (ADDRESS_BITS > AW) && (char_address_i == '1);
    end
    if (cmd_i.cap1) begin
      t1_q <= rd_val;
    end
    if (cmd_i.cap2) begin
      t2_q <= rd_val;
    end
    if (cmd_i.mul_step) begin
      prod_q <= (mcnt_q == 2'd0) ? mul_p : (prod_q + {mul_p[31:0], 32'b0});
    end
    if (div_start) begin
      neg_q <= t2_q[W-1] ^ t1_q[W-1];
    end
    if (mod_start) begin
      msrc_q <= t1_q;
      mrem_q <= '0;
    end else if (mrun_q) begin
      msrc_q <= msrc_q << 4;
      mrem_q <= mod_t[SpW-1:0];
    end
    if (cmd_i.apply) begin
      case (op_q)
        smci_pkg::OP_PRINT: begin
          kind_q <= smci_pkg::KIND_PRINT;
          val_q  <= t1_q;
        end
        smci_pkg::OP_PUTC: begin
          kind_q <= smci_pkg::KIND_PUTC;
          val_q  <= W'(t1_q[7:0]);
        end
        smci_pkg::OP_JUMP:   next_q <= t1_q[AW-1:0] & AddrMask;
        smci_pkg::OP_JUMPIF: next_q <= t2_q[AW-1:0] & AddrMask;
        smci_pkg::OP_DIV:    kind_q <= smci_pkg::KIND_DIVZERO;
        default: begin
          kind_q <= smci_pkg::KIND_UNKNOWN;
          val_q  <= W'(ch_q);
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_kind_q  <= kind_q;
      out_val_q   <= val_q;
      out_next_q  <= next_q;
      out_fault_q <= fault_q;
    end
  end

  // Status to the controller.
  assign stat_o.clr_done = clr_done_q;
  assign stat_o.op       = op_q;
  assign stat_o.last     = last_q;
  assign stat_o.rd_pos   = !rd_val[W-1] && (rd_val != '0);
  assign stat_o.t1_zero  = (t1_q == '0);
  assign stat_o.mul_last = (mcnt_q == 2'd2);
  assign stat_o.div_done = (op_q == smci_pkg::OP_DIV) ? div_done : mdone_q;

  assign event_kind_o   = out_kind_q;
  assign event_value_o  = out_val_q;
  assign next_address_o = out_next_q;
  assign stack_fault_o  = out_fault_q;

endmodule

@@ rtl/smci_ctrl.sv @@
// ----------------------------------------------------------------------------
// smci_ctrl
// Controller: sequences the micro-steps of each program character and owns
// the input and output handshakes.
// ----------------------------------------------------------------------------
module smci_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  smci_pkg::dp_stat_t stat_i,
  output smci_pkg::dp_cmd_t  cmd_o
);

  localparam logic [4:0] ST_CLEAR    = 5'd0;
  localparam logic [4:0] ST_IDLE     = 5'd1;
  localparam logic [4:0] ST_DECODE   = 5'd2;
  localparam logic [4:0] ST_FLUSH    = 5'd3;
  localparam logic [4:0] ST_DISPATCH = 5'd4;
  localparam logic [4:0] ST_POP1     = 5'd5;
  localparam logic [4:0] ST_CAP1     = 5'd6;
  localparam logic [4:0] ST_POP2     = 5'd7;
  localparam logic [4:0] ST_CAP2     = 5'd8;
  localparam logic [4:0] ST_MUL      = 5'd9;
  localparam logic [4:0] ST_DIVGO    = 5'd10;
  localparam logic [4:0] ST_DIVWAIT  = 5'd11;
  localparam logic [4:0] ST_LOADRD   = 5'd12;
  localparam logic [4:0] ST_STORE    = 5'd13;
  localparam logic [4:0] ST_PUSH     = 5'd14;
  localparam logic [4:0] ST_PUSH2    = 5'd15;
  localparam logic [4:0] ST_APPLY    = 5'd16;
  localparam logic [4:0] ST_DONE     = 5'd17;

  logic [4:0]    state_q, state_d;
  logic          ovalid_q, ovalid_d;
  smci_pkg::op_e op;

  assign op = stat_i.op;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    cmd_o    = '0;
    cmd_o.push_src = smci_pkg::PUSH_ZERO;
    cmd_o.div_mod  = (op != smci_pkg::OP_DIV);
    unique case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (op == smci_pkg::OP_DIGIT) begin
          cmd_o.digit = 1'b1;
          state_d     = stat_i.last ? ST_FLUSH : ST_DONE;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = (op == smci_pkg::OP_DIGIT) ? ST_DONE : ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (op)
          smci_pkg::OP_ADDR, smci_pkg::OP_SERIAL: state_d = ST_PUSH;
          smci_pkg::OP_SPACE:                     state_d = ST_DONE;
          smci_pkg::OP_UNKNOWN:                   state_d = ST_APPLY;
          default:                                state_d = ST_POP1;
        endcase
      end
      ST_POP1: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_CAP1;
      end
      ST_CAP1: begin
        cmd_o.cap1 = 1'b1;
        case (op)
          smci_pkg::OP_JUMPIF: state_d = stat_i.rd_pos ? ST_POP2 : ST_DONE;
          smci_pkg::OP_DUP:    state_d = ST_PUSH;
          smci_pkg::OP_LOAD:   state_d = ST_DIVGO;
          smci_pkg::OP_JUMP, smci_pkg::OP_PRINT, smci_pkg::OP_PUTC:
            state_d = ST_APPLY;
          default:             state_d = ST_POP2;
        endcase
      end
      ST_POP2: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_CAP2;
      end
      ST_CAP2: begin
        cmd_o.cap2 = 1'b1;
        case (op)
          smci_pkg::OP_MUL:    state_d = ST_MUL;
          smci_pkg::OP_DIV:    state_d = ST_DIVGO;
          smci_pkg::OP_STORE:  state_d = ST_DIVGO;
          smci_pkg::OP_JUMPIF: state_d = ST_APPLY;
          default:             state_d = ST_PUSH;
        endcase
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) state_d = ST_PUSH;
      end
      ST_DIVGO: begin
        // A zero divisor skips the divider and pushes zero.
        if (op == smci_pkg::OP_DIV && stat_i.t1_zero) begin
          state_d = ST_PUSH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVWAIT;
        end
      end
      ST_DIVWAIT: begin
        if (stat_i.div_done) begin
          case (op)
            smci_pkg::OP_LOAD:  state_d = ST_LOADRD;
            smci_pkg::OP_STORE: state_d = ST_STORE;
            default:            state_d = ST_PUSH;
          endcase
        end
      end
      ST_LOADRD: begin
        cmd_o.load_rd = 1'b1;
        state_d       = ST_PUSH;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_DONE;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_DONE;
        case (op)
          smci_pkg::OP_ADD:    cmd_o.push_src = smci_pkg::PUSH_SUM;
          smci_pkg::OP_SUB:    cmd_o.push_src = smci_pkg::PUSH_DIFF;
          smci_pkg::OP_MUL:    cmd_o.push_src = smci_pkg::PUSH_PROD;
          smci_pkg::OP_DIV: begin
            if (stat_i.t1_zero) begin
              cmd_o.push_src = smci_pkg::PUSH_ZERO;
              state_d        = ST_APPLY;
            end else begin
              cmd_o.push_src = smci_pkg::PUSH_QUOT;
            end
          end
          smci_pkg::OP_LOAD:   cmd_o.push_src = smci_pkg::PUSH_LOAD;
          smci_pkg::OP_ADDR:   cmd_o.push_src = smci_pkg::PUSH_NEXT;
          smci_pkg::OP_SERIAL: cmd_o.push_src = smci_pkg::PUSH_SERIAL;
          smci_pkg::OP_DUP, smci_pkg::OP_SWAP: begin
            cmd_o.push_src = smci_pkg::PUSH_T1;
            state_d        = ST_PUSH2;
          end
          default:             cmd_o.push_src = smci_pkg::PUSH_ZERO;
        endcase
      end
      ST_PUSH2: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_src = (op == smci_pkg::OP_SWAP) ? smci_pkg::PUSH_T2
                                                   : smci_pkg::PUSH_T1;
        state_d        = ST_DONE;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;

endmodule
